// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/clns_pkg.sv
// Types, constants and tables of the character LCD nibble sequencer.
`default_nettype none

package clns_pkg;

   localparam int LINES_DEF   = 3;
   localparam int COLUMNS_DEF = 16;

   localparam int STEP_W = 6;

   localparam logic [3:0] CONTRAST_RESET = 4'd11;

   // last phase index of each kind of request
   localparam logic [STEP_W-1:0] STEP_LAST_INIT     = 6'd33;
   localparam logic [STEP_W-1:0] STEP_LAST_PULSE    = 6'd2;
   localparam logic [STEP_W-1:0] STEP_LAST_CONTRAST = 6'd5;
   localparam logic [STEP_W-1:0] STEP_LAST_BYTE     = 6'd1;

   // init layout: pulse, 4-bit entry, setup bytes, contrast bytes
   localparam logic [STEP_W-1:0] STEP_ENTRY    = 6'd3;
   localparam logic [STEP_W-1:0] STEP_SETUP    = 6'd10;
   localparam logic [STEP_W-1:0] STEP_CONTRAST = 6'd28;

   localparam logic [3:0] WAIT_PULSE = 4'd10;
   localparam logic [3:0] WAIT_ENTRY = 4'd5;
   localparam logic [3:0] WAIT_SYNC  = 4'd10;
   localparam logic [3:0] NIB_FUNC   = 4'h2;

   localparam logic [7:0] BYTE_CLEAR      = 8'h01;
   localparam logic [7:0] BYTE_CURSOR_ON  = 8'h0F;
   localparam logic [7:0] BYTE_CURSOR_OFF = 8'h0C;
   localparam logic [7:0] BYTE_EXT_SET    = 8'h29;
   localparam logic [7:0] BYTE_NORM_SET   = 8'h28;
   localparam logic [3:0] NIB_CONTRAST    = 4'h7;
   localparam logic [1:0] POS_PREFIX      = 2'b10;

   typedef enum logic [2:0] {
      CMD_INIT       = 3'd0,
      CMD_PULSE      = 3'd1,
      CMD_CLEAR      = 3'd2,
      CMD_CURSOR_ON  = 3'd3,
      CMD_CURSOR_OFF = 3'd4,
      CMD_POSITION   = 3'd5,
      CMD_WRITE      = 3'd6,
      CMD_CONTRAST   = 3'd7
   } cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] line;
      logic [4:0] offset;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       reset_n;
      logic       reg_select;
      logic       read_write;
      logic [3:0] nibble;
      logic       strobe_res;
      logic [3:0] wait_ms;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic              busy;
      cmd_type           cmd;
      logic [STEP_W-1:0] step;
      logic [7:0]        byte_val;
   } seq_status_type;

   function automatic logic [7:0] setup_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h29;
         4'd1:    b = 8'h15;
         4'd2:    b = 8'h54;
         4'd3:    b = 8'h6E;
         4'd4:    b = 8'h7B;
         4'd5:    b = 8'h28;
         4'd6:    b = 8'h0F;
         4'd7:    b = 8'h01;
         4'd8:    b = 8'h06;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] contrast_byte(input logic [1:0] k, input logic [3:0] c);
      logic [7:0] b;
      case (k)
         2'd0:    b = BYTE_EXT_SET;
         2'd1:    b = {NIB_CONTRAST, c};
         default: b = BYTE_NORM_SET;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: rtl/clns_phase.sv
// Phase generator: maps request kind and phase index to one bus phase.
`default_nettype none

module clns_phase (
   input  clns_pkg::seq_status_type stat,
   input  logic [3:0]               contrast,
   output clns_pkg::rsp_type        phase
);

   logic [clns_pkg::STEP_W-1:0] rel;
   logic [clns_pkg::STEP_W-1:0] last_step;
   logic [7:0]                  byte_sel;
   logic                        byte_rs;
   logic                        use_byte;

   always_comb begin
      phase         = '0;
      phase.reset_n = 1'b1;
      rel           = stat.step;
      last_step     = clns_pkg::STEP_LAST_BYTE;
      byte_sel      = stat.byte_val;
      byte_rs       = 1'b0;
      use_byte      = 1'b0;

      unique case (stat.cmd)
         clns_pkg::CMD_INIT: begin
            last_step = clns_pkg::STEP_LAST_INIT;
            if (stat.step < clns_pkg::STEP_ENTRY) begin
               phase.reset_n = (stat.step != 6'd1);
               phase.wait_ms = (stat.step == 6'd2) ? 4'd0 : clns_pkg::WAIT_PULSE;
            end else if (stat.step < clns_pkg::STEP_SETUP) begin
               // 4-bit entry handshake
               phase.wait_ms = clns_pkg::WAIT_ENTRY;
               case (stat.step)
                  6'd3: phase.nibble = clns_pkg::NIB_FUNC;
                  6'd4, 6'd5, 6'd6: begin
                     phase.nibble     = clns_pkg::NIB_FUNC;
                     phase.strobe_res = 1'b1;
                  end
                  6'd7, 6'd8: begin
                     phase.reg_select = 1'b1;
                     phase.read_write = 1'b1;
                     phase.strobe_res = 1'b1;
                  end
                  default: phase.wait_ms = clns_pkg::WAIT_SYNC;
               endcase
            end else if (stat.step < clns_pkg::STEP_CONTRAST) begin
               rel      = stat.step - clns_pkg::STEP_SETUP;
               byte_sel = clns_pkg::setup_byte(rel[4:1]);
               use_byte = 1'b1;
            end else begin
               rel      = stat.step - clns_pkg::STEP_CONTRAST;
               byte_sel = clns_pkg::contrast_byte(rel[2:1], contrast);
               use_byte = 1'b1;
            end
         end
         clns_pkg::CMD_PULSE: begin
            last_step     = clns_pkg::STEP_LAST_PULSE;
            phase.reset_n = (stat.step != 6'd1);
            phase.wait_ms = (stat.step == 6'd2) ? 4'd0 : clns_pkg::WAIT_PULSE;
         end
         clns_pkg::CMD_CONTRAST: begin
            last_step = clns_pkg::STEP_LAST_CONTRAST;
            byte_sel  = clns_pkg::contrast_byte(stat.step[2:1], stat.byte_val[3:0]);
            use_byte  = 1'b1;
         end
         clns_pkg::CMD_CLEAR, clns_pkg::CMD_CURSOR_ON, clns_pkg::CMD_CURSOR_OFF,
         clns_pkg::CMD_POSITION: begin
            use_byte = 1'b1;
         end
         clns_pkg::CMD_WRITE: begin
            byte_rs  = 1'b1;
            use_byte = 1'b1;
         end
      endcase

      // byte phases: high nibble on even index, low on odd
      if (use_byte) begin
         phase.reg_select = byte_rs;
         phase.nibble     = rel[0] ? byte_sel[3:0] : byte_sel[7:4];
         phase.strobe_res = 1'b1;
         phase.wait_ms    = 4'd0;
      end

      phase.last = (stat.step == last_step);
   end

endmodule

`default_nettype wire

// File: rtl/clns_seq.sv
// Sequencer: request capture, run state and phase counter.
`default_nettype none

module clns_seq #(
   parameter int LINES   = clns_pkg::LINES_DEF,
   parameter int COLUMNS = clns_pkg::COLUMNS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  clns_pkg::req_type        req,
   input  logic                     load,
   input  logic                     phase_last,
   output clns_pkg::seq_status_type stat
);

   clns_pkg::seq_state_type     state_ff, state_in;
   clns_pkg::cmd_type           cmd_ff, cmd_in;
   logic [clns_pkg::STEP_W-1:0] step_ff, step_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        emits;
   logic [7:0]                  req_byte;

   // request decode; rejected requests produce no phases
   always_comb begin
      emits    = 1'b1;
      req_byte = req.value;
      unique case (clns_pkg::cmd_type'(req.command))
         clns_pkg::CMD_CLEAR:      req_byte = clns_pkg::BYTE_CLEAR;
         clns_pkg::CMD_CURSOR_ON:  req_byte = clns_pkg::BYTE_CURSOR_ON;
         clns_pkg::CMD_CURSOR_OFF: req_byte = clns_pkg::BYTE_CURSOR_OFF;
         clns_pkg::CMD_POSITION: begin
            emits    = (32'(req.line) < LINES) && (32'(req.offset) < COLUMNS);
            req_byte = {clns_pkg::POS_PREFIX, req.line, req.offset[3:0]};
         end
         clns_pkg::CMD_CONTRAST:   emits = (req.value[7:4] == 4'd0);
         clns_pkg::CMD_INIT, clns_pkg::CMD_PULSE, clns_pkg::CMD_WRITE: begin
            req_byte = req.value;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clns_pkg::ST_IDLE: if (start && emits) state_in = clns_pkg::ST_RUN;
         clns_pkg::ST_RUN:  if (load && phase_last) state_in = clns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      stat.busy     = 1'b0;
      stat.cmd      = cmd_ff;
      stat.step     = step_ff;
      stat.byte_val = byte_ff;
      unique case (state_ff)
         clns_pkg::ST_IDLE: stat.busy = 1'b0;
         clns_pkg::ST_RUN:  stat.busy = 1'b1;
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      byte_in = byte_ff;
      step_in = step_ff;
      if (start) begin
         cmd_in  = clns_pkg::cmd_type'(req.command);
         byte_in = req_byte;
         step_in = '0;
      end else if (stat.busy && load) begin
         step_in = step_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clns_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// File: rtl/char_lcd_nibble_sequencer.sv
// The first phase is presented from the output register rsp_ff once the sequencer has entered its run state.
// A request of N phases (2, 3, 6 or 34 for init) is issued by the phase counter
// one phase a cycle when the result side does not stall; no new request is taken meanwhile.
// Rejected requests are accepted and emit nothing.
// Reset: synchronous; idles the sequencer, drops rsp_valid, contrast back to 11.
`default_nettype none
`include "assert_macros.svh"

module char_lcd_nibble_sequencer #(
   parameter int LINES   = clns_pkg::LINES_DEF,
   parameter int COLUMNS = clns_pkg::COLUMNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clns_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clns_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   clns_pkg::seq_status_type stat;
   clns_pkg::rsp_type        phase;
   clns_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               contrast_ff, contrast_in;
   logic                     start;
   logic                     load;

   assign csr_ready   = 1'b1;
   assign contrast_in = (csr_valid && csr_ready) ? csr_data : contrast_ff;

   assign req_stall = stat.busy;
   assign start     = req_valid && !req_stall;
   // output register can take a phase when empty or being drained
   assign load      = stat.busy && (!rsp_valid_ff || !rsp_stall);

   clns_seq #(
      .LINES   (LINES),
      .COLUMNS (COLUMNS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_payload),
      .load       (load),
      .phase_last (phase.last),
      .stat       (stat)
   );

   clns_phase u_phase (
      .stat     (stat),
      .contrast (contrast_ff),
      .phase    (phase)
   );

   always_comb begin
      rsp_in       = load ? phase : rsp_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         contrast_ff  <= clns_pkg::CONTRAST_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         contrast_ff  <= contrast_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEXT(a_last_ends_run, clock, reset, load && phase.last, !stat.busy, "run did not end after last phase")
   `ASSERT_NEXT(a_hold_step, clock, reset, stat.busy && !load && !phase.last, stat.busy && $stable(stat.step), "phase index moved while output blocked")
   `ASSERT_IMPL(a_step_range, clock, reset, stat.busy, stat.step <= clns_pkg::STEP_LAST_INIT, "phase index out of range")
   `ASSERT_IMPL(a_load_valid, clock, reset, rsp_valid && !rsp_stall && !stat.busy, !load, "phase loaded while idle")

endmodule

`default_nettype wire
